@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file wbps_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wbps_pkg.sv @@
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int WIN_DEPTH     = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
    localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
    localparam int FILL_W        = $clog2(WIN_DEPTH + 1);
    localparam int IDX_W         = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_WILDCARD_MASK  = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_WHICH_MATCH    = 3'd4,
        CFG_BASE_ADDRESS   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [31:0] match_address;
    } t_out_item;

    // Result as classified by the front: offset still relative to the range start.
    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_evt_beat;

endpackage

@@ rtl/wbps_queue.sv @@
`timescale 1ns / 1ps

module wbps_queue import wbps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_evt_beat i_push,
    output logic      o_full,
    output t_evt_beat o_head,
    input  logic      i_pop
);

    t_event            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.ev    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/wbps_front.sv @@
`timescale 1ns / 1ps

module wbps_front import wbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    input  logic                  i_queue_full,
    output logic                  o_in_stall,
    output t_evt_beat             o_push,
    output logic [31:0]           o_base_address
);

    // configuration
    logic [63:0]      r_pattern_low;
    logic [63:0]      r_pattern_high;
    logic [15:0]      r_wildcard_mask;
    logic [4:0]       r_pattern_length;
    logic [15:0]      r_which_match;
    logic [31:0]      r_base_address;

    // stream state
    logic [7:0]        r_window [WIN_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [31:0]       r_pos;
    logic [15:0]       r_matches_left;
    logic              r_reported;

    logic [127:0]      pattern;
    logic [7:0]        hist [PATTERN_BYTES];
    logic [LEN_W-1:0]  eff_len;
    logic              hit;
    logic              found_now;
    logic              accept;
    logic [31:0]       start_offset;

    assign pattern        = {r_pattern_high, r_pattern_low};
    assign o_in_stall     = i_queue_full;
    assign accept         = i_in_valid && !i_queue_full;
    assign o_base_address = r_base_address;

    always_comb begin
        eff_len = LEN_W'(r_pattern_length);
        if (r_pattern_length == 5'd0) begin
            eff_len = LEN_W'(1);
        end else if (r_pattern_length > 5'(PATTERN_BYTES)) begin
            eff_len = LEN_W'(PATTERN_BYTES);
        end
    end

    // hist[k] is the byte k positions back from the current one
    always_comb begin
        hist[0] = i_in_data.data_byte;
        for (int k = 1; k < PATTERN_BYTES; k++) begin
            hist[k] = r_window[k-1];
        end
    end

    // masked compare of each pattern position below the effective length against its aligned history byte
    always_comb begin
        logic [LEN_W-1:0] idx;
        hit = (LEN_W'(r_fill) + LEN_W'(1)) >= eff_len;
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            idx = eff_len - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < eff_len) && !r_wildcard_mask[i]) begin
                if (hist[idx[IDX_W-1:0]] != pattern[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    assign found_now    = hit && !r_reported && (r_matches_left <= 16'd1);
    assign start_offset = r_pos - 32'(eff_len - LEN_W'(1));

    always_comb begin
        o_push.valid     = accept && !r_reported && (found_now || i_in_data.last_byte);
        o_push.ev.found  = found_now;
        o_push.ev.offset = found_now ? start_offset : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_in_data.last_byte) begin
            r_window[0] <= i_in_data.data_byte;
            for (int k = 1; k < WIN_DEPTH; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_wildcard_mask  <= '0;
            r_pattern_length <= 5'd1;
            r_which_match    <= 16'd1;
            r_base_address   <= '0;
            r_fill           <= '0;
            r_pos            <= '0;
            r_matches_left   <= 16'd1;
            r_reported       <= 1'b0;
        end else begin
            if (accept) begin
                if (i_in_data.last_byte) begin
                    // rearm for the next range
                    r_fill         <= '0;
                    r_pos          <= '0;
                    r_matches_left <= r_which_match;
                    r_reported     <= 1'b0;
                end else begin
                    if (r_fill != FILL_W'(WIN_DEPTH)) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_pos <= r_pos + 32'd1;
                    if (hit && !r_reported) begin
                        if (r_matches_left <= 16'd1) begin
                            r_reported <= 1'b1;
                        end else begin
                            r_matches_left <= r_matches_left - 16'd1;
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                    CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                    CFG_WILDCARD_MASK:  r_wildcard_mask  <= i_cfg_data[15:0];
                    CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[4:0];
                    CFG_WHICH_MATCH: begin
                        r_which_match <= i_cfg_data[15:0];
                        // load the count only before the range has started
                        if ((r_pos == '0) && (r_fill == '0) && !r_reported) begin
                            r_matches_left <= i_cfg_data[15:0];
                        end
                    end
                    CFG_BASE_ADDRESS:   r_base_address   <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ rtl/wbps_back.sv @@
`timescale 1ns / 1ps

module wbps_back import wbps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_evt_beat   i_head,
    output logic        o_pop,
    input  logic [31:0] i_base_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    logic      r_valid;
    t_out_item r_data;
    t_out_item n_data;

    // refill the output register whenever it is empty or being taken
    assign o_pop = i_head.valid && (!r_valid || !i_out_stall);

    always_comb begin
        n_data.found         = i_head.ev.found;
        n_data.match_address = i_head.ev.found ? (i_base_address + i_head.ev.offset) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= i_head.valid;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

@@ rtl/wildcard_byte_pattern_scanner_top.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake                    Payload
// in       sink       i_in_valid / o_in_stall      i_in_data  (t_in_item)
// out      source     o_out_valid / i_out_stall    o_out_data (t_out_item)
// cfg      sink       i_cfg_we                     i_cfg_addr, i_cfg_data
//
// One byte per cycle while o_in_stall is low: the masked window compare runs in the accepting cycle.
// A result is registered in the result queue and then in the output register.
// Reset is synchronous, active low; no clearing pass is needed.
// o_in_stall rises only while the four-entry result queue is full, which
// takes a stalled output and several ranges ending meanwhile.

module wildcard_byte_pattern_scanner_top import wbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_evt_beat   push;
    t_evt_beat   head;
    logic        queue_full;
    logic        pop;
    logic [31:0] base_address;

    wbps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_data      (i_in_data),
        .i_queue_full   (queue_full),
        .o_in_stall     (o_in_stall),
        .o_push         (push),
        .o_base_address (base_address)
    );

    wbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    wbps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .i_base_address (base_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule

@@ rtl/wbps_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wbps_checker import wbps_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
                 o_out_valid && i_out_stall, o_out_valid,
                 "out beat dropped while stalled")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n,
                 o_out_valid && i_out_stall, $stable(o_out_data),
                 "out beat changed while stalled")
    `ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n,
                  o_out_valid && !o_out_data.found, o_out_data.match_address == 32'd0,
                  "miss beat carries an address")
    `ASSERT_IMPLY(a_out_cause, i_clk, i_rst_n,
                  $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2),
                  "out beat without an accepted byte")

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
